/* src/tcvg_pkg.sv */
// ----------------------------------------------------------------------------
// tcvg_pkg
// types, constants and helpers shared by the torus cell vertex generator
// ----------------------------------------------------------------------------
package tcvg_pkg;

   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int PHASE_W    = 16;
   localparam int NUM_W      = CNT_W + PHASE_W;
   localparam int MAX_SLICES = 1024;
   localparam int MAX_STACKS = 1024;
   localparam int COORD_W    = 16;
   localparam int RADIUS_W   = 16;
   localparam int TRIG_W     = 18;
   localparam int SINE_LAT   = 5;
   localparam int ADDR_W     = 4;

   typedef enum logic [1:0] {
      REG_TUBE_RADIUS = 2'd0,
      REG_RING_RADIUS = 2'd1,
      REG_SLICE_COUNT = 2'd2,
      REG_STACK_COUNT = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      TAG_A0 = 2'd0,
      TAG_A1 = 2'd1,
      TAG_B0 = 2'd2,
      TAG_B1 = 2'd3
   } tag_type;

   typedef struct packed {
      logic [IDX_W-1:0] slice_index;
      logic [IDX_W-1:0] stack_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [2:0]                vertex_number;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      tag_type            tag;
      logic [CNT_W-1:0]   divisor;
      logic [CNT_W-1:0]   rem;
      logic [NUM_W-1:0]   num;
      logic [PHASE_W-1:0] quo;
   } div_stage_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin;
      logic signed [TRIG_W-1:0] cos;
   } trig_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] vnum;
      trig_type   a;
      trig_type   b;
   } vtx_in_type;

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] maxc);
      logic [CNT_W-1:0] n;
      n = c;
      if (c == '0) n = CNT_W'(1);
      else if (c > maxc) n = maxc;
      return n;
   endfunction

   // corner of each vertex in the order p1,p2,p3,p1,p3,p4
   function automatic logic [1:0] corner_of(input logic [2:0] vnum);
      logic [1:0] c;
      case (vnum)
         3'd0: c = 2'd0;
         3'd1: c = 2'd1;
         3'd2: c = 2'd2;
         3'd3: c = 2'd0;
         3'd4: c = 2'd2;
         3'd5: c = 2'd3;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

endpackage

/* src/tcvg_div_cell.sv */
// ----------------------------------------------------------------------------
// tcvg_div_cell
// one restoring division step of the phase divider chain
// ----------------------------------------------------------------------------
module tcvg_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tcvg_pkg::div_stage_type stage_in,
   output tcvg_pkg::div_stage_type stage_out
);

   tcvg_pkg::div_stage_type stage_ff, next_in;
   logic [tcvg_pkg::CNT_W:0] trial;
   logic [tcvg_pkg::CNT_W:0] diff;
   logic                     ge;

   always_comb begin
      trial = {stage_in.rem, stage_in.num[tcvg_pkg::NUM_W-1]};
      diff  = trial - {1'b0, stage_in.divisor};
      ge    = (trial >= {1'b0, stage_in.divisor});
      next_in         = stage_in;
      next_in.valid   = stage_in.valid && !reset;
      next_in.rem     = ge ? diff[tcvg_pkg::CNT_W-1:0] : trial[tcvg_pkg::CNT_W-1:0];
      next_in.num     = {stage_in.num[tcvg_pkg::NUM_W-2:0], 1'b0};
      next_in.quo     = {stage_in.quo[tcvg_pkg::PHASE_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      stage_ff <= next_in;
   end

   assign stage_out = stage_ff;

endmodule

/* src/tcvg_sine.sv */
// ----------------------------------------------------------------------------
// tcvg_sine
// pipelined polynomial sine of a 16-bit phase, signed q3.15 result
// ----------------------------------------------------------------------------
module tcvg_sine (
   input  logic                              clock,
   input  logic [tcvg_pkg::PHASE_W-1:0]      phase,
   output logic signed [tcvg_pkg::TRIG_W-1:0] sine
);

   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [14:0] SIN_B = 15'd21024;
   localparam logic [11:0] SIN_C = 12'd2320;

   logic [13:0] x;
   logic [14:0] t;
   logic [15:0] u0_ff, u1_ff, u2r_ff, u3_ff;
   logic        n0_ff, n1_ff, n2_ff, n3_ff;
   logic [16:0] u2_ff;
   logic [16:0] u2b_ff;
   logic [13:0] k_ff;
   logic [16:0] m_ff;
   logic signed [tcvg_pkg::TRIG_W-1:0] s_ff;

   logic [31:0] sq;
   logic [28:0] kp;
   logic [14:0] bk;
   logic [31:0] mp;
   logic [15:0] am;
   logic [31:0] sp;
   logic [16:0] s_mag;

   always_comb begin
      x     = phase[13:0];
      t     = phase[14] ? (15'd16384 - {1'b0, x}) : {1'b0, x};
      sq    = u0_ff * u0_ff;
      kp    = SIN_C * u2_ff;
      bk    = SIN_B - {1'b0, k_ff};
      mp    = u2b_ff[15:0] * {1'b0, bk};
      am    = SIN_A - m_ff[15:0];
      sp    = u3_ff * am;
      s_mag = sp[31:15];
   end

   always_ff @(posedge clock) begin
      u0_ff  <= {t, 1'b0};
      n0_ff  <= phase[15];
      u2_ff  <= sq[31:15];
      u1_ff  <= u0_ff;
      n1_ff  <= n0_ff;
      k_ff   <= kp[28:15];
      u2b_ff <= u2_ff;
      u2r_ff <= u1_ff;
      n2_ff  <= n1_ff;
      m_ff   <= mp[31:15];
      u3_ff  <= u2r_ff;
      n3_ff  <= n2_ff;
      s_ff   <= n3_ff ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
   end

   assign sine = s_ff;

endmodule

/* src/tcvg_vertex.sv */
// ----------------------------------------------------------------------------
// tcvg_vertex
// scales trig values by the radii and rounds to saturated q8.8 vertices
// ----------------------------------------------------------------------------
module tcvg_vertex (
   input  logic                              clock,
   input  logic                              reset,
   input  tcvg_pkg::vtx_in_type              vtx_in,
   input  logic [tcvg_pkg::RADIUS_W-1:0]     tube_radius,
   input  logic [tcvg_pkg::RADIUS_W-1:0]     ring_radius,
   output logic                              rsp_valid,
   output tcvg_pkg::rsp_type                 rsp_data
);

   function automatic logic signed [15:0] sat_x(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) r = 16'sh7FFF;
      else if (v < -24'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [15:0] sat_y(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) r = 16'sh7FFF;
      else if (v < -20'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   logic signed [35:0] w_in, w_ff;
   logic signed [34:0] y_in, y_ff;
   logic signed [tcvg_pkg::TRIG_W-1:0] ca_ff, sa_ff;
   logic [2:0]         vn0_ff, vn1_ff;
   logic               v0_ff, v1_ff;
   logic signed [53:0] xp_ff, zp_ff;
   logic signed [19:0] yr_ff;
   logic signed [53:0] xr, zr;
   logic signed [34:0] yr;
   tcvg_pkg::rsp_type  rsp_ff;
   logic               rsp_valid_ff;

   always_comb begin
      w_in = 36'($signed({1'b0, tube_radius}) * vtx_in.b.sin)
           + $signed({5'b0, ring_radius, 15'b0});
      y_in = $signed({1'b0, tube_radius}) * vtx_in.b.cos;
      yr   = y_ff + 35'sd16384;
      xr   = xp_ff + 54'sd536870912;
      zr   = zp_ff + 54'sd536870912;
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      y_ff   <= y_in;
      ca_ff  <= vtx_in.a.cos;
      sa_ff  <= vtx_in.a.sin;
      vn0_ff <= vtx_in.vnum;
      xp_ff  <= w_ff * ca_ff;
      zp_ff  <= w_ff * sa_ff;
      yr_ff  <= yr[34:15];
      vn1_ff <= vn0_ff;
      rsp_ff.pos_x         <= sat_x(xr[53:30]);
      rsp_ff.pos_y         <= sat_y(yr_ff);
      rsp_ff.pos_z         <= sat_x(zr[53:30]);
      rsp_ff.vertex_number <= vn1_ff;
      rsp_ff.last          <= (vn1_ff == 3'd5);
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= vtx_in.valid;
         v1_ff        <= v0_ff;
         rsp_valid_ff <= v1_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/torus_cell_vertex_generator.sv */
// ----------------------------------------------------------------------------
// torus_cell_vertex_generator
// emits the six vertices of one torus mesh cell from its slice and stack index
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  input     start, busy, req_data                   start high, busy low
//  result    rsp_valid, rsp_data                     one cycle per strobe
//  config    psel, penable, pwrite, paddr, pwdata    access phase, pready high
//
//  a cell is taken while busy is low: four phase divisions enter the divider
//  chain one per cycle, the result port then gives one vertex per cycle; a
//  new cell can be taken before the vertices of the last one are out
//  vertices reach the result port through the 27-cell divider chain, the
//  5-stage sine, the vertex sequencer and the 3-stage vertex pipeline;
//  reset is synchronous and clears all control state
//  results cannot be stalled
// ----------------------------------------------------------------------------
module torus_cell_vertex_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tcvg_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output tcvg_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcvg_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam logic [tcvg_pkg::CNT_W-1:0] MAX_S = tcvg_pkg::CNT_W'(tcvg_pkg::MAX_SLICES);
   localparam logic [tcvg_pkg::CNT_W-1:0] MAX_T = tcvg_pkg::CNT_W'(tcvg_pkg::MAX_STACKS);

   // configuration
   logic [15:0] tube_ff, ring_ff;
   logic [tcvg_pkg::CNT_W-1:0] slices_ff, stacks_ff;
   tcvg_pkg::reg_index_type    widx;
   logic                       wr;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign widx   = tcvg_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tube_ff   <= 16'd256;
         ring_ff   <= 16'd512;
         slices_ff <= 11'd16;
         stacks_ff <= 11'd16;
      end else if (wr) begin
         case (widx)
            tcvg_pkg::REG_TUBE_RADIUS: tube_ff   <= pwdata[15:0];
            tcvg_pkg::REG_RING_RADIUS: ring_ff   <= pwdata[15:0];
            tcvg_pkg::REG_SLICE_COUNT: slices_ff <= pwdata[10:0];
            tcvg_pkg::REG_STACK_COUNT: stacks_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         tcvg_pkg::REG_TUBE_RADIUS: prdata = {16'b0, tube_ff};
         tcvg_pkg::REG_RING_RADIUS: prdata = {16'b0, ring_ff};
         tcvg_pkg::REG_SLICE_COUNT: prdata = {21'b0, slices_ff};
         tcvg_pkg::REG_STACK_COUNT: prdata = {21'b0, stacks_ff};
         default: prdata = '0;
      endcase
   end

   // issue four divisions per cell
   tcvg_pkg::req_type item_ff;
   logic [2:0]        cnt_ff;
   logic [1:0]        tag;
   logic [tcvg_pkg::IDX_W-1:0] idx;
   tcvg_pkg::div_stage_type    div_chain [0:tcvg_pkg::NUM_W];

   assign busy = (cnt_ff != 3'd0);
   assign tag  = 2'(cnt_ff - 3'd1);

   always_ff @(posedge clock) begin
      if (start && !busy) item_ff <= req_data;
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (start && !busy) begin
         cnt_ff <= 3'd1;
      end else if (busy) begin
         cnt_ff <= (cnt_ff == 3'd5) ? 3'd0 : cnt_ff + 3'd1;
      end
   end

   always_comb begin
      idx = tag[1] ? item_ff.stack_index : item_ff.slice_index;
      div_chain[0].valid   = (cnt_ff != 3'd0) && (cnt_ff <= 3'd4);
      div_chain[0].tag     = tcvg_pkg::tag_type'(tag);
      div_chain[0].divisor = tag[1] ? tcvg_pkg::eff_count(stacks_ff, MAX_T)
                                    : tcvg_pkg::eff_count(slices_ff, MAX_S);
      div_chain[0].rem     = '0;
      div_chain[0].num     = {({1'b0, idx} + {10'b0, tag[0]}), 16'b0};
      div_chain[0].quo     = '0;
   end

   for (genvar i = 0; i < tcvg_pkg::NUM_W; i++) begin : g_div
      tcvg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (div_chain[i]),
         .stage_out (div_chain[i+1])
      );
   end

   // sine and cosine of each phase
   tcvg_pkg::div_stage_type div_out;
   logic signed [tcvg_pkg::TRIG_W-1:0] sin_v, cos_v;
   logic    tv_ff  [0:tcvg_pkg::SINE_LAT-1];
   tcvg_pkg::tag_type tt_ff [0:tcvg_pkg::SINE_LAT-1];

   assign div_out = div_chain[tcvg_pkg::NUM_W];

   tcvg_sine u_sin (
      .clock (clock),
      .phase (div_out.quo),
      .sine  (sin_v)
   );

   tcvg_sine u_cos (
      .clock (clock),
      .phase (div_out.quo + 16'd16384),
      .sine  (cos_v)
   );

   always_ff @(posedge clock) begin
      tt_ff[0] <= div_out.tag;
      for (int i = 1; i < tcvg_pkg::SINE_LAT; i++) tt_ff[i] <= tt_ff[i-1];
      if (reset) begin
         for (int i = 0; i < tcvg_pkg::SINE_LAT; i++) tv_ff[i] <= 1'b0;
      end else begin
         tv_ff[0] <= div_out.valid;
         for (int i = 1; i < tcvg_pkg::SINE_LAT; i++) tv_ff[i] <= tv_ff[i-1];
      end
   end

   // collect the four phases, then hand the cell to the vertex sequencer
   tcvg_pkg::trig_type trig_v;
   tcvg_pkg::trig_type col_a0_ff, col_a1_ff, col_b0_ff;
   tcvg_pkg::trig_type fr_a0_ff, fr_a1_ff, fr_b0_ff, fr_b1_ff;
   logic               load;
   logic               seq_act_ff;
   logic [2:0]         seq_cnt_ff;
   logic [1:0]         corner;
   tcvg_pkg::vtx_in_type vtx_in;

   assign trig_v.sin = sin_v;
   assign trig_v.cos = cos_v;
   assign load = tv_ff[tcvg_pkg::SINE_LAT-1] &&
                 (tt_ff[tcvg_pkg::SINE_LAT-1] == tcvg_pkg::TAG_B1);

   always_ff @(posedge clock) begin
      if (tv_ff[tcvg_pkg::SINE_LAT-1]) begin
         case (tt_ff[tcvg_pkg::SINE_LAT-1])
            tcvg_pkg::TAG_A0: col_a0_ff <= trig_v;
            tcvg_pkg::TAG_A1: col_a1_ff <= trig_v;
            tcvg_pkg::TAG_B0: col_b0_ff <= trig_v;
            default: ;
         endcase
      end
      if (load) begin
         fr_a0_ff <= col_a0_ff;
         fr_a1_ff <= col_a1_ff;
         fr_b0_ff <= col_b0_ff;
         fr_b1_ff <= trig_v;
      end
      if (reset) begin
         seq_act_ff <= 1'b0;
         seq_cnt_ff <= 3'd0;
      end else if (load) begin
         seq_act_ff <= 1'b1;
         seq_cnt_ff <= 3'd0;
      end else if (seq_act_ff) begin
         seq_act_ff <= (seq_cnt_ff != 3'd5);
         seq_cnt_ff <= (seq_cnt_ff == 3'd5) ? 3'd0 : seq_cnt_ff + 3'd1;
      end
   end

   always_comb begin
      corner       = tcvg_pkg::corner_of(seq_cnt_ff);
      vtx_in.valid = seq_act_ff;
      vtx_in.vnum  = seq_cnt_ff;
      vtx_in.a     = corner[1] ? fr_a1_ff : fr_a0_ff;
      vtx_in.b     = (corner == 2'd1 || corner == 2'd2) ? fr_b1_ff : fr_b0_ff;
   end

   tcvg_vertex u_vertex (
      .clock       (clock),
      .reset       (reset),
      .vtx_in      (vtx_in),
      .tube_radius (tube_ff),
      .ring_radius (ring_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
